@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the retransmit tracker RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/rrt_pkg.sv @@
// ---------------------------------------------------------------------------
// rrt_pkg
// Types and constants shared by the retransmit request tracker modules.
// ---------------------------------------------------------------------------
package rrt_pkg;

  localparam int SLOTS       = 8;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_RES     = 8;
  localparam int RES_W       = $clog2(MAX_RES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 88;
  localparam int CFG_ADDR_W  = 4;

  localparam logic [1:0] REG_TIMEOUT     = 2'd0;
  localparam logic [1:0] REG_MAX_RETRIES = 2'd1;
  localparam logic [1:0] REG_FIRST_ID    = 2'd2;

  localparam logic [31:0] TIMEOUT_RST     = 32'd1000;
  localparam logic [3:0]  MAX_RETRIES_RST = 4'd3;
  localparam logic [31:0] FIRST_ID_RST    = 32'd1;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NACK = 2'd2,
    KIND_TICK = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    EV_SENT    = 2'd0,
    EV_FULL    = 2'd1,
    EV_RETX    = 2'd2,
    EV_GAVE_UP = 2'd3
  } event_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] request_id;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    event_t      event_res;
    logic [2:0]  slot;
    logic [31:0] request_id;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
  } result_t;

  typedef struct packed {
    logic [31:0] timeout_ms;
    logic [3:0]  max_retries;
    logic        id_load;
    logic [31:0] id_value;
  } cfg_t;

endpackage

@@ sv/rrt_front.sv @@
// ---------------------------------------------------------------------------
// rrt_front
// Accepts request items, decodes their kind and queues them for the engine.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rrt_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // request_id, peer_ip, peer_port, now_ms
  input  logic [rrt_pkg::IN_TDATA_W-1:0] in_tdata,
  // kind
  input  logic [1:0]                     in_tuser,
  input  logic                           pop,
  output logic                           item_valid,
  output rrt_pkg::item_t                 item
);

  rrt_pkg::item_t                    q_r [rrt_pkg::QUEUE_DEPTH];
  logic [rrt_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [rrt_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [rrt_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;
  rrt_pkg::item_t                    in_item;
  logic                              push;
  logic                              do_pop;

  always_comb begin
    in_item.kind       = rrt_pkg::kind_t'(in_tuser);
    in_item.request_id = in_tdata[31:0];
    in_item.peer_ip    = in_tdata[63:32];
    in_item.peer_port  = in_tdata[79:64];
    in_item.now_ms     = in_tdata[111:80];
  end

  assign in_tready  = (cnt_r != rrt_pkg::QCNT_W'(rrt_pkg::QUEUE_DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rd_ptr_r];
  assign push       = in_tvalid && in_tready;
  assign do_pop     = pop && item_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == rrt_pkg::QPTR_W'(rrt_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_r + rrt_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == rrt_pkg::QPTR_W'(rrt_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_r + rrt_pkg::QPTR_W'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + rrt_pkg::QCNT_W'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - rrt_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

  `ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= rrt_pkg::QCNT_W'(rrt_pkg::QUEUE_DEPTH))
  `ASSERT_NEXT(a_cnt_grow, clk, rst_n, push && !do_pop, cnt_r == $past(cnt_r) + rrt_pkg::QCNT_W'(1))
  `ASSERT_IMPL(a_ptr_gap, clk, rst_n, cnt_r == '0, wr_ptr_r == rd_ptr_r)

endmodule

@@ sv/rrt_back.sv @@
// ---------------------------------------------------------------------------
// rrt_back
// Slot table, scan engine: one slot per cycle unless stalled; hold/out regs.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rrt_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rrt_pkg::cfg_t                   cfg,
  input  logic                            item_valid,
  input  rrt_pkg::item_t                  item,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // slot, request_id_res, dest_ip, dest_port, zero pad
  output logic [rrt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // event_res
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

  localparam int SLOTS  = rrt_pkg::SLOTS;
  localparam int SLOT_W = rrt_pkg::SLOT_W;
  localparam int RES_W  = rrt_pkg::RES_W;

  logic [31:0]       rid_r     [SLOTS];
  logic [31:0]       sent_r    [SLOTS];
  logic [3:0]        retries_r [SLOTS];
  logic [31:0]       ip_r      [SLOTS];
  logic [15:0]       port_r    [SLOTS];

  state_t            state_r, state_nxt;
  logic [SLOTS-1:0]  busy_r, busy_nxt;
  logic [31:0]       next_id_r, next_id_nxt;
  rrt_pkg::item_t    cur_r, cur_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [RES_W-1:0]  nres_r, nres_nxt;
  logic              hold_v_r, hold_v_nxt;
  rrt_pkg::result_t  hold_r, hold_nxt;
  logic              out_v_r, out_v_nxt;
  rrt_pkg::result_t  out_r, out_nxt;
  logic              out_last_r, out_last_nxt;

  logic              rd_busy;
  logic [31:0]       rd_rid;
  logic [31:0]       rd_sent;
  logic [3:0]        rd_retries;
  logic [31:0]       elapsed;
  logic              last_idx;
  logic              out_free;
  logic              can_emit;
  logic              id_match;
  logic              due;
  logic              retry_ok;
  logic              emit;
  logic              done;
  rrt_pkg::result_t  res;
  logic              we_entry;
  logic              we_retx;
  logic [3:0]        retries_inc;

  assign rd_busy     = busy_r[idx_r];
  assign rd_rid      = rid_r[idx_r];
  assign rd_sent     = sent_r[idx_r];
  assign rd_retries  = retries_r[idx_r];
  assign elapsed     = cur_r.now_ms - rd_sent;
  assign last_idx    = (idx_r == SLOT_W'(SLOTS - 1));
  assign out_free    = !out_v_r || out_tready;
  assign can_emit    = !hold_v_r || out_free;
  assign id_match    = rd_busy && (rd_rid == cur_r.request_id);
  assign due         = rd_busy && (elapsed >= cfg.timeout_ms);
  assign retry_ok    = rd_retries < cfg.max_retries;
  assign retries_inc = rd_retries + 4'd1;

  always_comb begin
    state_nxt    = state_r;
    busy_nxt     = busy_r;
    next_id_nxt  = next_id_r;
    cur_nxt      = cur_r;
    idx_nxt      = idx_r;
    nres_nxt     = nres_r;
    hold_v_nxt   = hold_v_r;
    hold_nxt     = hold_r;
    out_v_nxt    = out_v_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    pop          = 1'b0;
    emit         = 1'b0;
    done         = 1'b0;
    res          = '0;
    we_entry     = 1'b0;
    we_retx      = 1'b0;

    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          pop       = 1'b1;
          cur_nxt   = item;
          idx_nxt   = '0;
          nres_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (can_emit) begin
          unique case (cur_r.kind)
            rrt_pkg::KIND_SEND: begin
              if (!rd_busy) begin
                emit             = 1'b1;
                done             = 1'b1;
                we_entry         = 1'b1;
                busy_nxt[idx_r]  = 1'b1;
                next_id_nxt      = next_id_r + 32'd1;
                res.event_res    = rrt_pkg::EV_SENT;
                res.slot         = 3'(idx_r);
                res.request_id   = next_id_r;
                res.dest_ip      = cur_r.peer_ip;
                res.dest_port    = cur_r.peer_port;
              end else if (last_idx) begin
                emit          = 1'b1;
                done          = 1'b1;
                res.event_res = rrt_pkg::EV_FULL;
              end
            end
            rrt_pkg::KIND_ACK: begin
              if (id_match) begin
                busy_nxt[idx_r] = 1'b0;
                done            = 1'b1;
              end else if (last_idx) begin
                done = 1'b1;
              end
            end
            rrt_pkg::KIND_NACK: begin
              if (id_match) begin
                emit           = 1'b1;
                done           = 1'b1;
                res.slot       = 3'(idx_r);
                res.request_id = cur_r.request_id;
                if (retry_ok) begin
                  we_retx       = 1'b1;
                  res.event_res = rrt_pkg::EV_RETX;
                  res.dest_ip   = cur_r.peer_ip;
                  res.dest_port = cur_r.peer_port;
                end else begin
                  busy_nxt[idx_r] = 1'b0;
                  res.event_res   = rrt_pkg::EV_GAVE_UP;
                end
              end else if (last_idx) begin
                done = 1'b1;
              end
            end
            rrt_pkg::KIND_TICK: begin
              if (due) begin
                emit           = 1'b1;
                res.slot       = 3'(idx_r);
                res.request_id = rd_rid;
                if (retry_ok) begin
                  we_retx       = 1'b1;
                  res.event_res = rrt_pkg::EV_RETX;
                  res.dest_ip   = ip_r[idx_r];
                  res.dest_port = port_r[idx_r];
                end else begin
                  busy_nxt[idx_r] = 1'b0;
                  res.event_res   = rrt_pkg::EV_GAVE_UP;
                end
                if (nres_r == RES_W'(rrt_pkg::MAX_RES - 1)) begin
                  done = 1'b1;
                end
              end
              if (last_idx) begin
                done = 1'b1;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase

          if (emit) begin
            if (hold_v_r) begin
              out_v_nxt    = 1'b1;
              out_nxt      = hold_r;
              out_last_nxt = 1'b0;
            end
            hold_v_nxt = 1'b1;
            hold_nxt   = res;
            nres_nxt   = nres_r + RES_W'(1);
          end

          if (done) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + SLOT_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_nxt      = hold_r;
          out_last_nxt = 1'b1;
          hold_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg.id_load) begin
      next_id_nxt = cfg.id_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      busy_r     <= '0;
      next_id_r  <= rrt_pkg::FIRST_ID_RST;
      idx_r      <= '0;
      nres_r     <= '0;
      hold_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      busy_r     <= busy_nxt;
      next_id_r  <= next_id_nxt;
      idx_r      <= idx_nxt;
      nres_r     <= nres_nxt;
      hold_v_r   <= hold_v_nxt;
      out_v_r    <= out_v_nxt;
      out_last_r <= out_last_nxt;
    end
    cur_r  <= cur_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (we_entry) begin
      rid_r[idx_r]     <= next_id_r;
      sent_r[idx_r]    <= cur_r.now_ms;
      retries_r[idx_r] <= 4'd0;
      ip_r[idx_r]      <= cur_r.peer_ip;
      port_r[idx_r]    <= cur_r.peer_port;
    end else if (we_retx) begin
      sent_r[idx_r]    <= cur_r.now_ms;
      retries_r[idx_r] <= retries_inc;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_r.dest_port, out_r.dest_ip, out_r.request_id, out_r.slot};
  assign out_tuser  = out_r.event_res;
  assign out_tlast  = out_last_r;

  `ASSERT_IMPL(a_idle_no_hold, clk, rst_n, state_r == ST_IDLE, !hold_v_r)
  `ASSERT_IMPL(a_hold_counted, clk, rst_n, hold_v_r, nres_r != '0)
  `ASSERT_IMPL(a_nres_bound, clk, rst_n, 1'b1, nres_r <= RES_W'(rrt_pkg::MAX_RES))
  `ASSERT_NEXT(a_id_only_send, clk, rst_n, (state_r != ST_SCAN || cur_r.kind != rrt_pkg::KIND_SEND) && !cfg.id_load, $stable(next_id_r))

endmodule

@@ sv/retransmit_request_tracker.sv @@
// ---------------------------------------------------------------------------
// retransmit_request_tracker
// Slot table that tracks outstanding reliable requests and flags resends.
// ---------------------------------------------------------------------------
// An accepted item enters a two-entry queue, so up to two items can wait
// while the engine works; the input is ready whenever an entry is free. The
// engine takes one item at a time and reads one table slot per cycle, unless
// the output stalls it, through its single read port: it loads the item in
// IDLE, examines slots in SCAN (a send stops at the first free slot, an ack
// or nack at the first busy match, a tick walks all slots), and releases any
// final result in FLUSH. Results leave through one output register with tlast
// on the final result of each item; an ack or an unmatched nack or an idle
// tick gives no result. Slot busy flags clear at reset; no clearing pass is
// needed.
// ---------------------------------------------------------------------------
module retransmit_request_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // request_id, peer_ip, peer_port, now_ms
  input  logic [rrt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // slot, request_id_res, dest_ip, dest_port, zero pad
  output logic [rrt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // event_res
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rrt_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  logic [31:0]    timeout_r, timeout_nxt;
  logic [3:0]     max_retries_r, max_retries_nxt;
  logic [31:0]    first_id_r, first_id_nxt;
  logic           cfg_wr;
  logic [1:0]     reg_idx;
  rrt_pkg::cfg_t  cfg;
  logic           pop;
  logic           item_valid;
  rrt_pkg::item_t item;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_comb begin
    timeout_nxt     = timeout_r;
    max_retries_nxt = max_retries_r;
    first_id_nxt    = first_id_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        rrt_pkg::REG_TIMEOUT:     timeout_nxt     = cfg_pwdata;
        rrt_pkg::REG_MAX_RETRIES: max_retries_nxt = cfg_pwdata[3:0];
        rrt_pkg::REG_FIRST_ID:    first_id_nxt    = cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rrt_pkg::REG_TIMEOUT:     cfg_prdata = timeout_r;
      rrt_pkg::REG_MAX_RETRIES: cfg_prdata = {28'd0, max_retries_r};
      rrt_pkg::REG_FIRST_ID:    cfg_prdata = first_id_r;
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= rrt_pkg::TIMEOUT_RST;
      max_retries_r <= rrt_pkg::MAX_RETRIES_RST;
      first_id_r    <= rrt_pkg::FIRST_ID_RST;
    end else begin
      timeout_r     <= timeout_nxt;
      max_retries_r <= max_retries_nxt;
      first_id_r    <= first_id_nxt;
    end
  end

  always_comb begin
    cfg.timeout_ms  = timeout_r;
    cfg.max_retries = max_retries_r;
    cfg.id_load     = cfg_wr && (reg_idx == rrt_pkg::REG_FIRST_ID);
    cfg.id_value    = cfg_pwdata;
  end

  rrt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .pop        (pop),
    .item_valid (item_valid),
    .item       (item)
  );

  rrt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ verif/tb_retransmit_request_tracker.sv @@
// ---------------------------------------------------------------------------
// tb_retransmit_request_tracker
// Self-checking bench for the retransmit request tracker. A table of directed
// requests exercises sends, acks, nacks and ticks: lowest-free-slot reuse,
// a full table, timeouts that wrap, and give-up after the retry budget.
// Random phases follow, each with its own register settings: zero and
// maximal timeout, zero and maximal retry budget, and a wrapping id counter.
// The request ids of acks and nacks are mostly taken from live slots. A
// slot-table predictor in the bench computes the expected results, and
// both ports idle at random outside the odd phases, which run gap-free.
// ---------------------------------------------------------------------------
module tb_retransmit_request_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import rrt_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 11;
  localparam int SETTLE_CYCLES   = 3 * (SLOTS + 2) + 10;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int ITEMS_PER_PHASE = 20;
  localparam int PHASES          = 5;
  localparam int REPORT_LIMIT    = 10;
  localparam int NOW_STRIDE      = 40;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    result_t res;
    logic    last;
  } tracker_event_t;

  typedef struct {
    item_t          it;
    bit             typed;
    bit             has_result;
    tracker_event_t want;
  } plan_row_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [1:0]             in_tuser    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [31:0]            cfg_pwdata  = '0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  // slot table as the block should hold it
  logic        slot_in_use [SLOTS] = '{default: 1'b0};
  logic [31:0] slot_rid    [SLOTS] = '{default: '0};
  logic [31:0] slot_sent   [SLOTS] = '{default: '0};
  logic [3:0]  slot_tries  [SLOTS] = '{default: '0};
  logic [31:0] slot_ip     [SLOTS] = '{default: '0};
  logic [15:0] slot_port   [SLOTS] = '{default: '0};
  logic [31:0] id_counter   = FIRST_ID_RST;
  logic [31:0] timeout_cfg  = TIMEOUT_RST;
  logic [3:0]  retry_limit  = MAX_RETRIES_RST;
  logic [31:0] first_id_cfg = FIRST_ID_RST;

  tracker_event_t awaited_events[$];
  tracker_event_t step_events[$];
  tracker_event_t seen;
  tracker_event_t oldest;

  logic [31:0] clock_ms = '0;
  bit          steady   = 1'b0;
  int          mismatches   = 0;
  int          items_done   = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  int          event_tally [4] = '{default: 0};

  retransmit_request_tracker u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void add_event(event_t ev, int s, logic [31:0] id,
                                    logic [31:0] ip, logic [15:0] port);
    tracker_event_t e;
    e.res  = '{ev, 3'(s), id, ip, port};
    e.last = 1'b0;
    step_events.push_back(e);
  endfunction

  function automatic int find_request(logic [31:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (slot_in_use[i] && slot_rid[i] == id) return i;
    return -1;
  endfunction

  function automatic void service_slot(int s, logic [31:0] now, logic [31:0] ip,
                                       logic [15:0] port);
    if (slot_tries[s] < retry_limit) begin
      slot_tries[s] = slot_tries[s] + 4'd1;
      slot_sent[s]  = now;
      add_event(EV_RETX, s, slot_rid[s], ip, port);
    end else begin
      slot_in_use[s] = 1'b0;
      add_event(EV_GAVE_UP, s, slot_rid[s], '0, '0);
    end
  endfunction

  function automatic void step_table(item_t it);
    int          hit;
    logic [31:0] elapsed;
    step_events.delete();
    hit = -1;
    case (it.kind)
      KIND_SEND: begin
        for (int i = 0; i < SLOTS; i++)
          if (!slot_in_use[i] && hit < 0) hit = i;
        if (hit < 0) begin
          add_event(EV_FULL, 0, '0, '0, '0);
        end else begin
          slot_in_use[hit] = 1'b1;
          slot_rid[hit]    = id_counter;
          slot_sent[hit]   = it.now_ms;
          slot_tries[hit]  = '0;
          slot_ip[hit]     = it.peer_ip;
          slot_port[hit]   = it.peer_port;
          add_event(EV_SENT, hit, id_counter, it.peer_ip, it.peer_port);
          id_counter = id_counter + 32'd1;
        end
      end
      KIND_ACK: begin
        hit = find_request(it.request_id);
        if (hit >= 0) slot_in_use[hit] = 1'b0;
      end
      KIND_NACK: begin
        hit = find_request(it.request_id);
        if (hit >= 0) service_slot(hit, it.now_ms, it.peer_ip, it.peer_port);
      end
      default: begin
        for (int i = 0; i < SLOTS && step_events.size() < MAX_RES; i++) begin
          elapsed = it.now_ms - slot_sent[i];
          if (slot_in_use[i] && elapsed >= timeout_cfg)
            service_slot(i, it.now_ms, slot_ip[i], slot_port[i]);
        end
      end
    endcase
    if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
  endfunction

  function automatic void apply_setting(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_TIMEOUT:     timeout_cfg = val;
      REG_MAX_RETRIES: retry_limit = val[3:0];
      REG_FIRST_ID: begin
        first_id_cfg = val;
        id_counter   = val;
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    roll;
    int    live[$];
    roll = $urandom_range(0, 99);
    if (roll < 35)      it.kind = KIND_SEND;
    else if (roll < 50) it.kind = KIND_ACK;
    else if (roll < 70) it.kind = KIND_NACK;
    else                it.kind = KIND_TICK;
    it.request_id = $urandom;
    it.peer_ip    = $urandom;
    it.peer_port  = 16'($urandom);
    for (int i = 0; i < SLOTS; i++)
      if (slot_in_use[i]) live.push_back(i);
    if (live.size() > 0 && $urandom_range(0, 3) != 0)
      it.request_id = slot_rid[live[$urandom_range(0, live.size() - 1)]];
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, NOW_STRIDE);
    it.now_ms = clock_ms;
    return it;
  endfunction

  function automatic plan_row_t make_row(kind_t k, logic [31:0] rid, logic [31:0] ip,
                                         logic [15:0] port, logic [31:0] now,
                                         bit typed = 1'b0, bit has_result = 1'b0,
                                         event_t ev = EV_SENT, logic [2:0] s = '0,
                                         logic [31:0] id = '0, logic [31:0] dip = '0,
                                         logic [15:0] dport = '0);
    plan_row_t r;
    r.it         = '{k, rid, ip, port, now};
    r.typed      = typed;
    r.has_result = has_result;
    r.want.res   = '{ev, s, id, dip, dport};
    r.want.last  = 1'b1;
    return r;
  endfunction

  function automatic string show(tracker_event_t e);
    return $sformatf("event=%0d slot=%0d id=%h ip=%h port=%h last=%0b", e.res.event_res,
                     e.res.slot, e.res.request_id, e.res.dest_ip, e.res.dest_port, e.last);
  endfunction

  task automatic count_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic push_item(input item_t it, input bit typed, input bit has_result,
                           input tracker_event_t want);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {it.now_ms, it.peer_port, it.peer_ip, it.request_id};
    do @(posedge clk); while (!in_tready);
    items_done++;
    step_table(it);
    if (typed) begin
      if (has_result) awaited_events.push_back(want);
    end else begin
      foreach (step_events[j]) awaited_events.push_back(step_events[j]);
    end
  endtask

  // hold input until every result is back and the engine has gone quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    apply_setting(idx, val);
  endtask

  task automatic check_register(input logic [1:0] idx, input logic [31:0] want);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (cfg_prdata !== want)
      count_mismatch($sformatf("register %0d read %h, expected %h", idx, cfg_prdata, want));
  endtask

  task automatic check_settings();
    check_register(REG_TIMEOUT, timeout_cfg);
    check_register(REG_MAX_RETRIES, {28'd0, retry_limit});
    check_register(REG_FIRST_ID, first_id_cfg);
  endtask

  initial begin : result_sink
    int hold;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      hold = steady ? 0 : pick_gap();
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      seen.res.event_res  = event_t'(out_tuser);
      seen.res.slot       = out_tdata[2:0];
      seen.res.request_id = out_tdata[34:3];
      seen.res.dest_ip    = out_tdata[66:35];
      seen.res.dest_port  = out_tdata[82:67];
      seen.last           = out_tlast;
      results_seen++;
      event_tally[out_tuser]++;
      if (awaited_events.size() == 0) begin
        count_mismatch({"unexpected result ", show(seen)});
      end else begin
        oldest = awaited_events.pop_front();
        if (oldest.res.event_res !== seen.res.event_res ||
            oldest.res.slot !== seen.res.slot ||
            oldest.res.request_id !== seen.res.request_id ||
            oldest.res.dest_ip !== seen.res.dest_ip ||
            oldest.res.dest_port !== seen.res.dest_port ||
            oldest.last !== seen.last)
          count_mismatch({"expected ", show(oldest), " got ", show(seen)});
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid === 1'b1 && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("tb_retransmit_request_tracker failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    plan_row_t   plan[$];
    logic [31:0] t_val;
    logic [31:0] r_val;
    logic [31:0] f_val;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_settings();

    plan.push_back(make_row(KIND_SEND, 32'h0, 32'h0, 16'h0, 32'h0,
                            1, 1, EV_SENT, 3'd0, 32'd1, 32'h0, 16'h0));
    plan.push_back(make_row(KIND_SEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFF0,
                            1, 1, EV_SENT, 3'd1, 32'd2, 32'hFFFF_FFFF, 16'hFFFF));
    plan.push_back(make_row(KIND_SEND, 32'h0, 32'hC0A8_0001, 16'h1F90, 32'd100,
                            1, 1, EV_SENT, 3'd2, 32'd3, 32'hC0A8_0001, 16'h1F90));
    plan.push_back(make_row(KIND_ACK, 32'd3, 32'h0, 16'h0, 32'd105, 1, 0));
    plan.push_back(make_row(KIND_ACK, 32'd3, 32'h0, 16'h0, 32'd106, 1, 0));
    plan.push_back(make_row(KIND_NACK, 32'h1234_5678, 32'h1, 16'h1, 32'd110, 1, 0));
    plan.push_back(make_row(KIND_NACK, 32'd1, 32'h0A00_0001, 16'h1388, 32'd50,
                            1, 1, EV_RETX, 3'd0, 32'd1, 32'h0A00_0001, 16'h1388));
    plan.push_back(make_row(KIND_TICK, 32'h0, 32'h0, 16'h0, 32'd500, 1, 0));
    plan.push_back(make_row(KIND_TICK, 32'h0, 32'h0, 16'h0, 32'd1050));
    for (int i = 0; i < 6; i++)
      plan.push_back(make_row(KIND_SEND, 32'h0, 32'h0A00_0010 + i, 16'(16'h2000 + i),
                              32'd1100));
    plan.push_back(make_row(KIND_SEND, 32'h0, 32'h0A00_0020, 16'h3000, 32'd1110,
                            1, 1, EV_FULL, 3'd0, 32'd0, 32'h0, 16'h0));
    plan.push_back(make_row(KIND_NACK, 32'd1, 32'h0A00_0002, 16'h1389, 32'd1200));
    plan.push_back(make_row(KIND_NACK, 32'd1, 32'h0A00_0003, 16'h138A, 32'd1210,
                            1, 1, EV_GAVE_UP, 3'd0, 32'd1, 32'h0, 16'h0));
    plan.push_back(make_row(KIND_TICK, 32'h0, 32'h0, 16'h0, 32'h8000_0000));
    plan.push_back(make_row(KIND_TICK, 32'h0, 32'h0, 16'h0, 32'h8000_0000, 1, 0));
    plan.push_back(make_row(KIND_SEND, 32'h0, 32'h5A5A_5A5A, 16'hA5A5, 32'h8000_0010,
                            1, 1, EV_SENT, 3'd0, 32'd10, 32'h5A5A_5A5A, 16'hA5A5));
    plan.push_back(make_row(KIND_ACK, 32'd9, 32'h0, 16'h0, 32'h8000_0011, 1, 0));

    foreach (plan[k]) push_item(plan[k].it, plan[k].typed, plan[k].has_result, plan[k].want);
    clock_ms = 32'h8000_0020;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin
          t_val = 32'd1;
          r_val = 32'd0;
          f_val = 32'hFFFF_FFFE;
        end
        1: begin
          t_val = 32'd0;
          r_val = 32'd15;
          f_val = 32'd1;
        end
        2: begin
          t_val = 32'hFFFF_FFFF;
          r_val = 32'd15;
          f_val = 32'd0;
        end
        3: begin
          t_val = $urandom_range(16, 300);
          r_val = $urandom_range(0, 15);
          f_val = $urandom;
        end
        default: begin
          t_val = 32'd200;
          r_val = 32'd2;
          f_val = 32'd7;
          // reuse a live id so new sends collide with it
          for (int i = 0; i < SLOTS; i++)
            if (slot_in_use[i]) f_val = slot_rid[i];
        end
      endcase
      cfg_write(REG_TIMEOUT, t_val);
      cfg_write(REG_MAX_RETRIES, r_val);
      cfg_write(REG_FIRST_ID, f_val);
      if (p == 0) cfg_write(REG_SPARE, $urandom);
      check_settings();
      steady = (p % 2 == 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) push_item(random_item(), 1'b0, 1'b0, '0);
    end
    steady = 1'b0;
    settle();

    $display("run covered %0d requests and %0d results over %0d register settings",
             items_done, results_seen, PHASES + 1);
    $display("results by kind: %0d sent, %0d table full, %0d resent, %0d given up",
             event_tally[EV_SENT], event_tally[EV_FULL], event_tally[EV_RETX],
             event_tally[EV_GAVE_UP]);
    if (mismatches == 0 && awaited_events.size() == 0) begin
      $display("tb_retransmit_request_tracker passed");
    end else begin
      $display("tb_retransmit_request_tracker failed");
    end
    $finish;
  end

endmodule
